/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of the I2C master block.
// CHK_PROP expects clk_i and rst_ni, CHK_ALWAYS expects clk_i, to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CHK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/i2cm_pkg.sv */
// Package of the I2C master bit engine: payload structs, request codes,
// bus phase encoding and default widths. Depends on nothing.
package i2cm_pkg;

  localparam int unsigned TICK_WIDTH_DEF  = 16;
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned HP_WIDTH        = 16;
  localparam int unsigned HALF_PERIOD_RST = 5;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_BYTE  = 2'd3
  } req_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_S0, PH_S1, PH_S2, PH_WH, PH_WL, PH_AK0, PH_AK1, PH_AK2,
    PH_WAIT, PH_R0, PH_RH, PH_RL, PH_R1, PH_MA0, PH_MA1, PH_MA2,
    PH_MN0, PH_MN1, PH_P0, PH_P1, PH_P2, PH_P3
  } phase_e;

  typedef struct packed {
    req_e        req_type;
    logic [6:0]  target_addr;
    logic [15:0] byte_count;
    logic        send_stop;
    logic [7:0]  wr_data;
    logic        sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       need_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic       done_res;
    logic       failed;
  } res_t;

endpackage

/* hw/rtl/i2cm_req_if.sv */
// Request channel of the I2C master: valid/ready handshake with a req_t payload.
// Depends on i2cm_pkg.
interface i2cm_req_if import i2cm_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/i2cm_res_if.sv */
// Result channel of the I2C master: valid/ready handshake with a res_t payload.
// Depends on i2cm_pkg.
interface i2cm_res_if import i2cm_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/i2c_master_bit_engine.sv */
// Top level of the I2C master bit engine: input register, sequencer and
// result register. Depends on i2cm_pkg, i2cm_req_if, i2cm_res_if, i2cm_engine.
//
//   Channel   Direction  Payload  Meaning
//   req       in         req_t    one timing tick with an optional request
//   res       out        res_t    line levels and events after that tick
//   cfg       in         16 bits  half_period, written with cfg_we_i
//
// A transaction waits in the input register until the sequencer steps it, and
// its result then sits in the result register until res accepts it.
// One transaction is taken every cycle while the result side keeps up; the
// sequencer's state update between the two registers is the only loop.
// A stall on res holds the result register and then the input register.
// Reset (rst_ni low) puts the bus in the idle state with SCL and SDA high.
module i2c_master_bit_engine import i2cm_pkg::*; #(
  parameter int unsigned TICK_WIDTH  = TICK_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [HP_WIDTH-1:0] cfg_wdata_i,
  i2cm_req_if.sink            req,
  i2cm_res_if.source          res
);

  logic in_vld_q, in_vld_d;
  req_t in_q;
  logic out_vld_q, out_vld_d;
  res_t out_q;
  res_t step_res;
  logic step;
  logic req_fire;

  assign step     = in_vld_q && (!out_vld_q || res.ready);
  assign req.ready = !in_vld_q || step;
  assign req_fire = req.valid && req.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (req_fire) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (res.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_q <= req.data;
    end
    if (step) begin
      out_q <= step_res;
    end
  end

  i2cm_engine #(
    .TICK_WIDTH  (TICK_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (in_q),
    .res_o       (step_res)
  );

  assign res.valid = out_vld_q;
  assign res.data  = out_q;

endmodule

/* hw/rtl/i2cm_engine.sv */
// Bus phase sequencer of the I2C master: state registers, the half period
// register and the combinational next-state and result logic. Uses i2cm_pkg.
module i2cm_engine import i2cm_pkg::*; #(
  parameter int unsigned TICK_WIDTH  = TICK_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [HP_WIDTH-1:0] cfg_wdata_i,
  input  logic                step_i,
  input  req_t                item_i,
  output res_t                res_o
);

  localparam int unsigned WIDE = (TICK_WIDTH > HP_WIDTH) ? TICK_WIDTH : HP_WIDTH;

  phase_e                 phase_q, phase_d;
  logic [TICK_WIDTH-1:0]  tick_q, tick_d;
  logic [TICK_WIDTH-1:0]  hp_q, hp_d;
  logic [2:0]             bit_q, bit_d;
  logic [7:0]             shift_q, shift_d;
  logic [COUNT_WIDTH-1:0] left_q, left_d;
  logic                   is_read_q, is_read_d;
  logic                   stop_q, stop_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic                   drv_q, drv_d;
  logic                   nack_q, nack_d;

  logic                   ev_valid;
  logic [7:0]             ev_data;
  logic                   ev_done;
  logic                   ev_failed;
  logic [WIDE-1:0]        hp_wide;

  // The phase length is clamped once, when the register is written.
  always_comb begin
    hp_wide = WIDE'(cfg_wdata_i);
    if (hp_wide == '0) begin
      hp_d = TICK_WIDTH'(1);
    end else if (hp_wide > WIDE'({TICK_WIDTH{1'b1}})) begin
      hp_d = {TICK_WIDTH{1'b1}};
    end else begin
      hp_d = TICK_WIDTH'(hp_wide);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q      <= TICK_WIDTH'(HALF_PERIOD_RST);
      phase_q   <= PH_IDLE;
      tick_q    <= '0;
      bit_q     <= '0;
      shift_q   <= '0;
      left_q    <= '0;
      is_read_q <= 1'b0;
      stop_q    <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      drv_q     <= 1'b1;
      nack_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hp_q <= hp_d;
      end
      if (step_i) begin
        phase_q   <= phase_d;
        tick_q    <= tick_d;
        bit_q     <= bit_d;
        shift_q   <= shift_d;
        left_q    <= left_d;
        is_read_q <= is_read_d;
        stop_q    <= stop_d;
        scl_q     <= scl_d;
        sda_q     <= sda_d;
        drv_q     <= drv_d;
        nack_q    <= nack_d;
      end
    end
  end

  always_comb begin
    logic go_stop;
    logic go_read;
    logic go_send;
    logic go_finish;

    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    left_d    = left_q;
    is_read_d = is_read_q;
    stop_d    = stop_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    drv_d     = drv_q;
    nack_d    = nack_q;
    ev_valid  = 1'b0;
    ev_data   = '0;
    ev_done   = 1'b0;
    ev_failed = 1'b0;
    go_stop   = 1'b0;
    go_read   = 1'b0;
    go_send   = 1'b0;
    go_finish = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (item_i.req_type == REQ_WRITE || item_i.req_type == REQ_READ) begin
        is_read_d = (item_i.req_type == REQ_READ);
        shift_d   = {item_i.target_addr, item_i.req_type == REQ_READ};
        left_d    = COUNT_WIDTH'(item_i.byte_count);
        stop_d    = item_i.send_stop;
        nack_d    = 1'b0;
        bit_d     = '0;
        scl_d     = 1'b1;
        sda_d     = 1'b1;
        drv_d     = 1'b1;
        phase_d   = PH_S0;
        tick_d    = hp_q;
      end
    end else if (phase_q == PH_WAIT) begin
      if (item_i.req_type == REQ_BYTE) begin
        left_d  = left_q - COUNT_WIDTH'(1);
        shift_d = item_i.wr_data;
        bit_d   = '0;
        go_send = 1'b1;
      end
    end else if (tick_q <= TICK_WIDTH'(1)) begin
      // The current phase has run its course: move to the next one.
      tick_d = hp_q;
      unique case (phase_q)
        PH_S0: begin
          sda_d = 1'b0;
          phase_d = PH_S1;
        end
        PH_S1: begin
          scl_d = 1'b0;
          phase_d = PH_S2;
        end
        PH_S2: begin
          bit_d = '0;
          go_send = 1'b1;
        end
        PH_WH: begin
          scl_d = 1'b0;
          if (bit_q == 3'd7) begin
            sda_d = 1'b1;
          end
          shift_d = {shift_q[6:0], 1'b0};
          phase_d = PH_WL;
        end
        PH_WL: begin
          if (bit_q == 3'd7) begin
            sda_d = 1'b1;
            drv_d = 1'b0;
            phase_d = PH_AK0;
          end else begin
            bit_d = bit_q + 3'd1;
            go_send = 1'b1;
          end
        end
        PH_AK0: begin
          scl_d = 1'b1;
          phase_d = PH_AK1;
        end
        PH_AK1: begin
          nack_d = item_i.sda_in;
          scl_d = 1'b0;
          drv_d = 1'b1;
          phase_d = PH_AK2;
        end
        PH_AK2: begin
          if (nack_q) begin
            go_stop = 1'b1;
          end else if (is_read_q) begin
            if (left_q != '0) begin
              go_read = 1'b1;
            end else begin
              go_stop = 1'b1;
            end
          end else if (left_q != '0) begin
            phase_d = PH_WAIT;
            tick_d = '0;
          end else if (stop_q) begin
            go_stop = 1'b1;
          end else begin
            go_finish = 1'b1;
          end
        end
        PH_R0: begin
          bit_d = '0;
          scl_d = 1'b1;
          phase_d = PH_RH;
        end
        PH_RH: begin
          shift_d = {shift_q[6:0], item_i.sda_in};
          scl_d = 1'b0;
          if (bit_q == 3'd7) begin
            ev_valid = 1'b1;
            ev_data = {shift_q[6:0], item_i.sda_in};
          end
          phase_d = PH_RL;
        end
        PH_RL: begin
          if (bit_q == 3'd7) begin
            drv_d = 1'b1;
            phase_d = PH_R1;
          end else begin
            bit_d = bit_q + 3'd1;
            scl_d = 1'b1;
            phase_d = PH_RH;
          end
        end
        PH_R1: begin
          // The master acknowledges every byte but the last.
          if (left_q != '0) begin
            sda_d = 1'b0;
            phase_d = PH_MA0;
          end else begin
            sda_d = 1'b1;
            phase_d = PH_MN0;
          end
        end
        PH_MA0: begin
          scl_d = 1'b1;
          phase_d = PH_MA1;
        end
        PH_MA1: begin
          scl_d = 1'b0;
          phase_d = PH_MA2;
        end
        PH_MA2: begin
          sda_d = 1'b1;
          if (left_q != '0) begin
            go_read = 1'b1;
          end else begin
            go_stop = 1'b1;
          end
        end
        PH_MN0: begin
          scl_d = 1'b1;
          phase_d = PH_MN1;
        end
        PH_MN1: begin
          scl_d = 1'b0;
          go_stop = 1'b1;
        end
        PH_P0: begin
          sda_d = 1'b0;
          phase_d = PH_P1;
        end
        PH_P1: begin
          scl_d = 1'b1;
          phase_d = PH_P2;
        end
        PH_P2: begin
          sda_d = 1'b1;
          phase_d = PH_P3;
        end
        PH_P3: begin
          go_finish = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
          tick_d = '0;
        end
      endcase
    end else begin
      tick_d = tick_q - TICK_WIDTH'(1);
    end

    if (go_send) begin
      sda_d = shift_d[7];
      scl_d = 1'b1;
      phase_d = PH_WH;
      tick_d = hp_q;
    end
    if (go_read) begin
      left_d = left_q - COUNT_WIDTH'(1);
      drv_d = 1'b0;
      phase_d = PH_R0;
    end
    if (go_stop) begin
      scl_d = 1'b0;
      drv_d = 1'b1;
      phase_d = PH_P0;
    end
    if (go_finish) begin
      phase_d = PH_IDLE;
      tick_d = '0;
      ev_done = 1'b1;
      ev_failed = nack_q;
    end
  end

  always_comb begin
    res_o.scl_out    = scl_d;
    res_o.sda_out    = sda_d;
    res_o.sda_drive  = drv_d;
    res_o.busy_res   = (phase_d != PH_IDLE);
    res_o.need_byte  = (phase_d == PH_WAIT);
    res_o.read_valid = ev_valid;
    res_o.read_data  = ev_data;
    res_o.done_res   = ev_done;
    res_o.failed     = ev_failed;
  end

endmodule

/* hw/rtl/i2cm_checker.sv */
// Port-level checks on the result channel of the I2C master bit engine.
// Depends on i2cm_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module i2cm_checker import i2cm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid_i,
  input logic res_ready_i,
  input res_t res_data_i
);

  // A stalled result must stay on the channel unchanged.
  `CHK_PROP(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i), "stalled result changed")

  // A finished transfer leaves the bus idle.
  `CHK_PROP(a_done_idle, res_valid_i && res_data_i.done_res |-> !res_data_i.busy_res, "done while busy")

  // Failure is only flagged together with done.
  `CHK_PROP(a_fail_done, res_valid_i && res_data_i.failed |-> res_data_i.done_res, "failed without done")

  // A received byte always lies inside a transfer.
  `CHK_PROP(a_read_busy, res_valid_i && res_data_i.read_valid |-> res_data_i.busy_res, "read byte while idle")

  // While a write byte is awaited the master holds SCL low and drives SDA.
  `CHK_PROP(a_wait_lines, res_valid_i && res_data_i.need_byte |-> res_data_i.busy_res && !res_data_i.scl_out && res_data_i.sda_drive, "bad line levels while waiting")

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res.valid),
  .res_ready_i (res.ready),
  .res_data_i  (res.data)
);
